/* src/hse_pkg.sv */
// ----------------------------------------------------------------------------
// hse_pkg
// Types and constants shared by the histogram statistics engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  localparam int unsigned VAL_W    = 7;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned CNT_W    = 23;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned PROD_W   = 30;
  localparam int unsigned PCT_FULL = 100;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic {
    KIND_INSERT,
    KIND_QUERY
  } item_kind_e;

  typedef struct packed {
    item_kind_e             kind;
    logic                   walk_en;
    logic [VAL_W-1:0]       value;
    logic [PCT_W-1:0]       pct;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_WALK_T,
    ST_WALK,
    ST_DONE
  } back_state_e;

endpackage

`default_nettype wire

/* src/hse_front.sv */
// ----------------------------------------------------------------------------
// hse_front
// Accepts input items, drops out-of-range inserts, flags queries whose
// threshold walk applies, and buffers work in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_front #(
  parameter int unsigned MAX_VALUE = 100
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      op_i,
  input  wire logic [hse_pkg::VAL_W-1:0] value_i,
  input  wire logic [hse_pkg::PCT_W-1:0] percentage_i,
  output logic                           item_valid_o,
  input  wire logic                      item_ready_i,
  output hse_pkg::item_t                 item_o
);
  import hse_pkg::*;

  item_t      slots_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       in_range, keep, push, pop;
  item_t      item_new;

  assign in_range = 32'(value_i) <= 32'(MAX_VALUE);
  assign keep     = (op_i == OP_QUERY) || in_range;

  always_comb begin
    item_new.kind    = (op_i == OP_QUERY) ? KIND_QUERY : KIND_INSERT;
    item_new.walk_en = in_range && (percentage_i <= PCT_W'(PCT_FULL));
    item_new.value   = value_i;
    item_new.pct     = percentage_i;
  end

  assign in_ready_o   = cnt_q != 2'd2;
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = cnt_q != 2'd0;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = slots_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slots_q[wptr_q] <= item_new;
  end

endmodule

`default_nettype wire

/* src/hse_div.sv */
// ----------------------------------------------------------------------------
// hse_div
// Restoring divider, one quotient bit per cycle, for the weighted sum over
// the sample count.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [hse_pkg::SUM_W-1:0] dividend_i,
  input  wire logic [hse_pkg::CNT_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic [hse_pkg::SUM_W-1:0]      quot_o,
  output logic [hse_pkg::CNT_W-1:0]      rem_o
);
  import hse_pkg::*;

  localparam int unsigned SW = $clog2(SUM_W);
  localparam logic [SW-1:0] STEPS_M1 = SW'(SUM_W - 1);

  logic [SUM_W-1:0] quot_q;
  logic [CNT_W-1:0] rem_q, divisor_q;
  logic [SW-1:0]    cnt_q;
  logic             busy_q;
  logic [CNT_W:0]   shifted;
  logic [CNT_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, quot_q[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
  assign ge      = !diff[CNT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEPS_M1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - SW'(1);
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[SUM_W-2:0], ge};
      rem_q  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* src/hse_back.sv */
// ----------------------------------------------------------------------------
// hse_back
// Holds the bin memory and running totals, carries out inserts, and answers
// queries with a scan up all bins and an optional downward threshold walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_back #(
  parameter int unsigned MAX_VALUE = 100,
  parameter int unsigned BIN_WIDTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  output logic                           item_ready_o,
  input  hse_pkg::item_t                 item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [hse_pkg::VAL_W-1:0]      mean_o,
  output logic [hse_pkg::VAL_W-1:0]      max_value_o,
  output logic [hse_pkg::VAL_W-1:0]      min_value_o,
  output logic [hse_pkg::VAL_W-1:0]      median_o,
  output logic [hse_pkg::CNT_W-1:0]      count_above_o,
  output logic [hse_pkg::CNT_W-1:0]      count_below_o,
  output logic [hse_pkg::VAL_W-1:0]      shift_o
);
  import hse_pkg::*;

  localparam int unsigned NBINS = MAX_VALUE + 1;
  localparam int unsigned IW    = $clog2(NBINS);
  localparam int unsigned CW    = (IW > VAL_W) ? IW : VAL_W;
  localparam logic [IW-1:0] LAST = IW'(MAX_VALUE);
  localparam logic [BIN_WIDTH-1:0] BIN_FULL = '1;

  // bin memory, entries read as zero until first written
  logic [BIN_WIDTH-1:0] mem [NBINS];
  logic [BIN_WIDTH-1:0] mem_rd_q;
  logic [NBINS-1:0]     valid_q;
  logic                 rd_ok_q;
  logic [BIN_WIDTH-1:0] rdata;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]  total_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]  t_q;
  logic              walk_en_q;
  logic [IW-1:0]     proc_q, j_q, mx_q, mn_q, med_q, t_idx;
  logic              mn_found_q, med_found_q;
  logic [CNT_W-1:0]  run_q, above_q, below_q, pass_q, run_sum, bin_cnt;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  shift_q;

  logic [IW-1:0]     rd_addr;
  logic              wr_en, pop, div_start, walk_go, ins_ok, out_load;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic              div_busy;
  logic [VAL_W-1:0]  mean_val;

  logic                 out_valid_q;
  logic [VAL_W-1:0]     mean_q, mx_out_q, mn_out_q, med_out_q, shift_out_q;
  logic [CNT_W-1:0]     above_out_q, below_out_q;

  assign rdata   = rd_ok_q ? mem_rd_q : '0;
  assign bin_cnt = CNT_W'(rdata);
  assign run_sum = run_q + bin_cnt;
  assign t_idx   = walk_en_q ? IW'(t_q) : '0;
  assign pop     = item_valid_i && item_ready_o;
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(t_q);
  assign ins_ok  = (rdata != BIN_FULL) && (total_q != '1) && !sum_ext[SUM_W];
  assign walk_go = (j_q != '0) && (prod_q > PROD_W'(pass_q) * PROD_W'(PCT_FULL));
  assign out_load = (state_q == ST_DONE) && !div_busy && (!out_valid_q || out_ready_i);

  assign item_ready_o = state_q == ST_IDLE;

  always_comb begin
    state_d   = state_q;
    rd_addr   = '0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (item_i.kind == KIND_INSERT) begin
            rd_addr = IW'(item_i.value);
            state_d = ST_INS;
          end else begin
            div_start = 1'b1;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_INS: begin
        wr_en   = ins_ok;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (proc_q == LAST) begin
          rd_addr = t_idx;
          state_d = walk_en_q ? ST_WALK_T : ST_DONE;
        end else begin
          rd_addr = proc_q + IW'(1);
        end
      end
      ST_WALK_T: begin
        rd_addr = (t_idx != '0) ? t_idx - IW'(1) : '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        rd_addr = (j_q > IW'(1)) ? j_q - IW'(2) : '0;
        if (!walk_go) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        valid_q[IW'(t_q)] <= 1'b1;
        total_q <= total_q + CNT_W'(1);
        sum_q   <= sum_ext[SUM_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem[rd_addr];
    rd_ok_q  <= valid_q[rd_addr];
    if (wr_en) mem[IW'(t_q)] <= rdata + BIN_WIDTH'(1);
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        t_q         <= item_i.value;
        walk_en_q   <= item_i.walk_en;
        prod_q      <= PROD_W'(item_i.pct) * PROD_W'(total_q);
        proc_q      <= '0;
        run_q       <= '0;
        above_q     <= '0;
        below_q     <= '0;
        mx_q        <= '0;
        mn_q        <= LAST;
        med_q       <= '0;
        mn_found_q  <= 1'b0;
        med_found_q <= 1'b0;
        shift_q     <= '0;
      end
      ST_SCAN: begin
        proc_q <= proc_q + IW'(1);
        run_q  <= run_sum;
        if (rdata != '0 && proc_q != '0) mx_q <= proc_q;
        if (rdata != '0 && proc_q != LAST && !mn_found_q) begin
          mn_q       <= proc_q;
          mn_found_q <= 1'b1;
        end
        if (!med_found_q && {run_sum, 1'b0} >= {1'b0, total_q}) begin
          med_q       <= proc_q;
          med_found_q <= 1'b1;
        end
        if (CW'(proc_q) > CW'(t_q)) above_q <= above_q + bin_cnt;
        if (CW'(proc_q) < CW'(t_q)) below_q <= below_q + bin_cnt;
      end
      ST_WALK_T: begin
        pass_q <= above_q + bin_cnt;
        j_q    <= t_idx;
      end
      ST_WALK: begin
        if (walk_go) begin
          pass_q <= pass_q + bin_cnt;
          j_q    <= j_q - IW'(1);
        end else begin
          shift_q <= VAL_W'(t_idx - j_q);
        end
      end
      ST_INS, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  hse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // round up only when the remainder is over half the count
  always_comb begin
    if (total_q == '0) begin
      mean_val = '0;
    end else if ({rem, 1'b0} > {1'b0, total_q}) begin
      mean_val = VAL_W'(quot + SUM_W'(1));
    end else begin
      mean_val = VAL_W'(quot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q      <= mean_val;
      mx_out_q    <= VAL_W'(mx_q);
      mn_out_q    <= VAL_W'(mn_q);
      med_out_q   <= VAL_W'(med_q);
      above_out_q <= walk_en_q || (32'(t_q) <= 32'(MAX_VALUE)) ? above_q : '0;
      below_out_q <= below_q;
      shift_out_q <= shift_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mean_o        = mean_q;
  assign max_value_o   = mx_out_q;
  assign min_value_o   = mn_out_q;
  assign median_o      = med_out_q;
  assign count_above_o = above_out_q;
  assign count_below_o = below_out_q;
  assign shift_o       = shift_out_q;

endmodule

`default_nettype wire

/* src/histogram_statistics_engine_unit.sv */
// ----------------------------------------------------------------------------
// histogram_statistics_engine_unit
// Histogram of sample values with mean, extremes, median, threshold counts
// and percentage shift on query.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): op 0 inserts value into its bin, op 1 queries
// with value as threshold and percentage as required share. Inserts above
// MAX_VALUE are dropped at the input and give no result.
// Output channel (valid/ready): one result per query, held in an output
// register until transferred; the engine keeps taking inputs into its
// two-entry queue while a result waits.
// Flow: an insert occupies the back end for its read and its write state.
// A query scans every bin (one memory read per bin), then, where it applies,
// walks down from the threshold (one bin per cycle), then registers the
// result; the mean divider runs alongside the scan. The back end takes a
// new item only once it is through with the last one.
// Reset clears the bins (per-bin valid flags), the totals and all handshake
// state at once; the block is ready in the first cycle after reset.
// When the receiver stalls, a further finished query waits in the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_statistics_engine_unit #(
  parameter int unsigned MAX_VALUE = 100,
  parameter int unsigned BIN_WIDTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      op_i,
  input  wire logic [hse_pkg::VAL_W-1:0] value_i,
  input  wire logic [hse_pkg::PCT_W-1:0] percentage_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [hse_pkg::VAL_W-1:0]      mean_o,
  output logic [hse_pkg::VAL_W-1:0]      max_value_o,
  output logic [hse_pkg::VAL_W-1:0]      min_value_o,
  output logic [hse_pkg::VAL_W-1:0]      median_o,
  output logic [hse_pkg::CNT_W-1:0]      count_above_o,
  output logic [hse_pkg::CNT_W-1:0]      count_below_o,
  output logic [hse_pkg::VAL_W-1:0]      shift_o
);
  import hse_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  hse_front #(
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .percentage_i (percentage_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  hse_back #(
    .MAX_VALUE (MAX_VALUE),
    .BIN_WIDTH (BIN_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mean_o        (mean_o),
    .max_value_o   (max_value_o),
    .min_value_o   (min_value_o),
    .median_o      (median_o),
    .count_above_o (count_above_o),
    .count_below_o (count_below_o),
    .shift_o       (shift_o)
  );

endmodule

`default_nettype wire

/* src/hse_checker.sv */
// ----------------------------------------------------------------------------
// hse_checker
// Port-level checks on the histogram statistics engine result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [hse_pkg::VAL_W-1:0] mean_o,
  input wire logic [hse_pkg::VAL_W-1:0] max_value_o,
  input wire logic [hse_pkg::VAL_W-1:0] median_o,
  input wire logic [hse_pkg::CNT_W-1:0] count_above_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_o)
      && $stable(count_above_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

  // the mean never lies above the highest occupied bin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_o <= max_value_o)
    else $error("mean above max");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> median_o <= max_value_o)
    else $error("median above max");

endmodule

bind histogram_statistics_engine_unit hse_checker u_hse_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the histogram statistics engine: drives inserts and
// queries over valid/ready, predicts every query result from its own copy of
// the histogram and compares each transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hse_pkg::*;

  localparam int unsigned TOP_BIN   = 100;
  localparam int unsigned BIN_LIMIT = 65535;
  localparam int unsigned CYCLE_CAP = 1000000;

  typedef struct {
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] max_value;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] median;
    logic [CNT_W-1:0] count_above;
    logic [CNT_W-1:0] count_below;
    logic [VAL_W-1:0] shift;
  } stats_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic [VAL_W-1:0] value_i;
  logic [PCT_W-1:0] percentage_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [VAL_W-1:0] mean_o, max_value_o, min_value_o, median_o, shift_o;
  logic [CNT_W-1:0] count_above_o, count_below_o;

  histogram_statistics_engine_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .value_i, .percentage_i,
    .out_valid_o, .out_ready_i, .mean_o, .max_value_o, .min_value_o, .median_o,
    .count_above_o, .count_below_o, .shift_o
  );

  // predictor state
  int unsigned hist_bins[TOP_BIN+1];
  longint unsigned sample_count;
  longint unsigned sample_sum;
  stats_t pending_stats[$];

  int unsigned err_count;
  int unsigned query_count;
  int unsigned insert_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("histogram_statistics_engine_unit test failed");
        $finish;
      end
    end
  end

  function automatic void apply_insert(int unsigned v);
    if (v > TOP_BIN) return;
    if (hist_bins[v] >= BIN_LIMIT) return;
    hist_bins[v]++;
    sample_count++;
    sample_sum += v;
  endfunction

  function automatic stats_t compute_stats(int unsigned t, int unsigned pct);
    stats_t s;
    longint unsigned q, r, run, above, below, pass;
    int unsigned j;
    s.mean = '0;
    s.max_value = '0;
    s.min_value = VAL_W'(TOP_BIN);
    s.median = '0;
    s.shift = '0;
    if (sample_count != 0) begin
      q = sample_sum / sample_count;
      r = sample_sum % sample_count;
      s.mean = VAL_W'((2 * r > sample_count) ? q + 1 : q);
    end
    for (int i = TOP_BIN; i > 0; i--) begin
      if (hist_bins[i] != 0) begin
        s.max_value = VAL_W'(i);
        break;
      end
    end
    for (int i = 0; i < TOP_BIN; i++) begin
      if (hist_bins[i] != 0) begin
        s.min_value = VAL_W'(i);
        break;
      end
    end
    run = 0;
    for (int i = 0; i <= TOP_BIN; i++) begin
      run += hist_bins[i];
      if (2 * run >= sample_count) begin
        s.median = VAL_W'(i);
        break;
      end
    end
    above = 0;
    below = 0;
    for (int i = 0; i <= TOP_BIN; i++) begin
      if (i > t) above += hist_bins[i];
      if (i < t) below += hist_bins[i];
    end
    s.count_above = CNT_W'(above);
    s.count_below = CNT_W'(below);
    if (t <= TOP_BIN && pct <= PCT_FULL) begin
      pass = above + hist_bins[t];
      j = t;
      while (j > 0 && pct * sample_count > PCT_FULL * pass) begin
        pass += hist_bins[j-1];
        j--;
      end
      s.shift = VAL_W'(t - j);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    err_count++;
  endtask

  // sends one transfer; the predictor is updated at acceptance
  // valid drops only while the sender idles, so back-to-back items keep it high
  task automatic send_item(logic op, int unsigned v, int unsigned pct);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    value_i      <= VAL_W'(v);
    percentage_i <= PCT_W'(pct);
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_QUERY) begin
      pending_stats.push_back(compute_stats(v, pct));
      query_count++;
    end else begin
      apply_insert(v);
      insert_count++;
    end
  endtask

  // receiver: random stall, compare on transfer
  initial begin
    stats_t e;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = pending_stats.pop_front();
          if (mean_o !== e.mean) report_mismatch("mean", mean_o, e.mean);
          if (max_value_o !== e.max_value)
            report_mismatch("max_value", max_value_o, e.max_value);
          if (min_value_o !== e.min_value)
            report_mismatch("min_value", min_value_o, e.min_value);
          if (median_o !== e.median) report_mismatch("median", median_o, e.median);
          if (count_above_o !== e.count_above)
            report_mismatch("count_above", count_above_o, e.count_above);
          if (count_below_o !== e.count_below)
            report_mismatch("count_below", count_below_o, e.count_below);
          if (shift_o !== e.shift) report_mismatch("shift", shift_o, e.shift);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_empty_and_extremes();
    send_item(OP_QUERY, 0, 0);
    send_item(OP_QUERY, 127, 127);
    send_item(OP_INSERT, 127, 0);       // above top, dropped
    send_item(OP_INSERT, 101, 0);
    send_item(OP_INSERT, 100, 0);       // only the top bin occupied
    send_item(OP_QUERY, 50, 50);
    send_item(OP_INSERT, 0, 127);
    send_item(OP_INSERT, 0, 0);
    send_item(OP_INSERT, 1, 0);
    send_item(OP_QUERY, 100, 100);
    send_item(OP_QUERY, 101, 50);       // threshold above top
    send_item(OP_QUERY, 60, 101);       // percentage above one hundred
    send_item(OP_QUERY, 0, 100);
    send_item(OP_QUERY, 100, 1);
    send_item(OP_QUERY, 85, 42);
    send_item(OP_QUERY, 42, 85);        // walk down to bin 0
  endtask

  task automatic test_random(int unsigned n);
    int unsigned v, p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        v = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(TOP_BIN);
        p = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(PCT_FULL);
        send_item(OP_QUERY, v, p);
      end else begin
        v = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(TOP_BIN);
        send_item(OP_INSERT, v, $urandom_range(127));
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    err_count = 0;
    query_count = 0;
    insert_count = 0;
    sample_count = 0;
    sample_sum = 0;
    foreach (hist_bins[i]) hist_bins[i] = 0;
    send_idle_pct = 24;
    recv_idle_pct = 55;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OP_INSERT;
    value_i <= '0;
    percentage_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_random(130);
    send_idle_pct = 55;
    recv_idle_pct = 24;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    drain();

    $display("covered %0d inserts and %0d queries, empty and edge cases first,",
             insert_count, query_count);
    $display("then random traffic under three sender and receiver stall mixes");
    if (err_count == 0) begin
      $display("histogram_statistics_engine_unit test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("histogram_statistics_engine_unit test failed");
    end
    $finish;
  end

endmodule
